// ----- rtl/core/pmts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmts_pkg
// Shared types and constants of the multilevel task scheduler.
// ----------------------------------------------------------------------------
package pmts_pkg;

  localparam int unsigned LVL_W = 3;
  localparam int unsigned DUR_W = 16;
  localparam int unsigned TAG_W = 8;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [DUR_W-1:0] dur;
    logic [DUR_W-1:0] rest;
    logic [TAG_W-1:0] tag;
  } job_t;

  typedef struct packed {
    logic       command;
    logic [1:0] task_level;
    logic [15:0] task_duration;
    logic [7:0] task_tag;
  } cmd_t;

  typedef struct packed {
    logic        running_valid;
    logic [7:0]  running_tag;
    logic [15:0] running_left;
    logic        task_finished;
    logic        all_idle;
    logic        dropped;
    logic [15:0] tick_number;
  } res_t;

endpackage

// ----- rtl/core/pmts_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmts_cmd_if / pmts_res_if
// Valid/ready channels for command and result beats.
// ----------------------------------------------------------------------------
interface pmts_cmd_if;
  logic           valid;
  logic           ready;
  pmts_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pmts_res_if;
  logic           valid;
  logic           ready;
  pmts_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/preemptive_multilevel_task_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_multilevel_task_scheduler_unit
// Priority FIFOs, suspend stack and a sequencer that moves one head per visit.
// ----------------------------------------------------------------------------
// Arrival: the command beat is registered, ST_ARR appends it, and the result
// beat is registered. Tick: SCAN visits the levels from the highest down, DEC
// moves each FIFO head, PWAIT/PARK resume a suspended task ahead of a head,
// and FWAIT/FIN run the task. One command at a time: a new beat is
// accepted from the cycle after the result beat is taken.
// Reset clears pointers, fill counts, the stack top, the running slot and sets
// the tick count to 1; FIFO and stack RAM contents are never read before written.
module preemptive_multilevel_task_scheduler_unit #(
  parameter int unsigned LEVELS      = 3,
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned FIFO_DEPTH  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  pmts_cmd_if.sink   cmd_i,
  pmts_res_if.source res_o
);
  import pmts_pkg::*;

  localparam int unsigned LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned FW  = $clog2(FIFO_DEPTH);
  localparam int unsigned CW  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned TW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(LEVELS * FIFO_DEPTH);

  // SCAN picks the level, DEC moves one head, PWAIT/PARK handle a resumed
  // task, FWAIT/FIN run the task for one tick and build the result.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_ARR   = 8'b00000010,
    ST_SCAN  = 8'b00000100,
    ST_DEC   = 8'b00001000,
    ST_PWAIT = 8'b00010000,
    ST_PARK  = 8'b00100000,
    ST_FWAIT = 8'b01000000,
    ST_FIN   = 8'b10000000
  } state_e;

  state_e state_q;

  // FIFO and stack RAMs
  job_t fifo_mem [LEVELS*FIFO_DEPTH];
  job_t stk_mem  [STACK_DEPTH];
  job_t head_q, top_q;

  logic [FW-1:0] rptr_q [LEVELS];
  logic [CW-1:0] fill_q [LEVELS];
  logic [TW-1:0] top_idx_q;
  logic          busy_q;
  job_t          run_q;
  logic [15:0]   tick_q;
  cmd_t          cmd_q;
  logic [LW-1:0] lvl_q;
  logic          drop_q;
  res_t          res_q;
  logic          res_vld_q;

  // FIFO write port (arrival) and read port (head of lvl_q)
  logic          f_we;
  logic [AW-1:0] f_waddr, f_raddr;
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  job_t          s_wdata, f_wdata;

  logic [LW-1:0] alvl;
  logic          arr_ok;
  logic [31:0]   wsum;
  logic [FW-1:0] wslot;
  logic [FW-1:0] rnext;
  logic          lvl_last;

  logic stk_ne, stk_full, top_gt, preempt, park_now;
  logic all_empty;

  logic        fin_pop, fin_act, fin_live, fin_idle;
  job_t        fin_cur;
  logic [15:0] fin_rest;

  // Both RAMs are read every cycle into a register; an address change shows in the next cycle.
  always_ff @(posedge clk_i) begin
    if (f_we) fifo_mem[f_waddr] <= f_wdata;
    head_q <= fifo_mem[f_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (s_we) stk_mem[s_waddr] <= s_wdata;
    top_q <= stk_mem[s_raddr];
  end

  // Arrival slot: wrap the ring index by compare and subtract.
  assign alvl   = LW'(cmd_q.task_level);
  assign arr_ok = (32'(cmd_q.task_level) < LEVELS) &&
                  (32'(fill_q[alvl]) < FIFO_DEPTH);
  assign wsum   = 32'(rptr_q[alvl]) + 32'(fill_q[alvl]);
  assign wslot  = (wsum >= FIFO_DEPTH) ? FW'(wsum - FIFO_DEPTH) : FW'(wsum);

  // Read pointer after a head leaves its FIFO.
  assign rnext    = (32'(rptr_q[lvl_q]) + 32'd1 >= FIFO_DEPTH) ? '0
                                                               : rptr_q[lvl_q] + FW'(1);
  assign lvl_last = (fill_q[lvl_q] == CW'(1));

  // shared decision unit on head_q / top_q / run_q
  assign stk_ne   = (top_idx_q != '0);
  assign stk_full = (32'(top_idx_q) >= STACK_DEPTH);
  assign top_gt   = stk_ne && (top_q.lvl > head_q.lvl);
  assign preempt  = busy_q && (head_q.lvl > run_q.lvl) && (run_q.rest > (run_q.dur >> 1));
  assign park_now = !stk_ne || (top_q.lvl <= head_q.lvl);

  always_comb begin
    all_empty = 1'b1;
    for (int l = 0; l < LEVELS; l++) if (fill_q[l] != '0) all_empty = 1'b0;
  end

  // Run stage: keep the running task, or resume the stack top when idle.
  assign fin_pop  = !busy_q && stk_ne;
  assign fin_act  = busy_q || stk_ne;
  assign fin_cur  = busy_q ? run_q : top_q;
  assign fin_rest = fin_cur.rest - 16'd1;
  assign fin_live = fin_act && (fin_rest != 16'd0);
  assign fin_idle = !fin_live && (top_idx_q == TW'(fin_pop)) && all_empty;

  always_comb begin
    f_we    = (state_q == ST_ARR) && arr_ok;
    f_waddr = AW'(32'(alvl) * FIFO_DEPTH + 32'(wslot));
    f_wdata = '{lvl: LVL_W'(cmd_q.task_level), dur: cmd_q.task_duration,
                rest: cmd_q.task_duration, tag: cmd_q.task_tag};
    f_raddr = AW'(32'(lvl_q) * FIFO_DEPTH + 32'(rptr_q[lvl_q]));
    s_raddr = SW'(top_idx_q - TW'(1));
    s_waddr = SW'(top_idx_q);
    // push the preempted task or the parked head
    s_wdata = (state_q == ST_DEC && preempt) ? run_q : head_q;
    s_we    = 1'b0;
    if (state_q == ST_DEC && busy_q && (preempt || !top_gt) && !stk_full) s_we = 1'b1;
    if (state_q == ST_PARK && park_now && !stk_full) s_we = 1'b1;
  end

  assign cmd_i.ready = (state_q == ST_IDLE) && !res_vld_q;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      busy_q    <= 1'b0;
      run_q     <= '0;
      top_idx_q <= '0;
      tick_q    <= 16'd1;
      res_vld_q <= 1'b0;
      res_q     <= '0;
      cmd_q     <= '0;
      drop_q    <= 1'b0;
      lvl_q     <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        rptr_q[l] <= '0;
        fill_q[l] <= '0;
      end
    end else begin
      if (res_o.valid && res_o.ready) res_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_i.valid && cmd_i.ready) begin
            cmd_q   <= cmd_i.data;
            drop_q  <= 1'b0;
            lvl_q   <= LW'(LEVELS - 1);
            state_q <= (cmd_i.data.command == CMD_ARRIVE) ? ST_ARR : ST_SCAN;
          end
        end
        ST_ARR: begin
          // append to the level FIFO, or drop on a bad level or a full FIFO
          if (arr_ok) fill_q[alvl] <= fill_q[alvl] + CW'(1);
          res_q <= '{running_valid: 1'b0, running_tag: '0, running_left: '0,
                     task_finished: 1'b0,
                     all_idle: !arr_ok && !busy_q && !stk_ne && all_empty,
                     dropped: !arr_ok, tick_number: tick_q};
          res_vld_q <= 1'b1;
          state_q   <= ST_IDLE;
        end
        ST_SCAN: begin
          // head and stack top reads are in flight; skip empty levels
          if (fill_q[lvl_q] == '0) begin
            if (lvl_q == '0) state_q <= ST_FWAIT;
            else lvl_q <= lvl_q - LW'(1);
          end else begin
            state_q <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (!busy_q && top_gt) begin
            // resume the stack top; the head is parked or not after a re-read
            run_q     <= top_q;
            busy_q    <= 1'b1;
            top_idx_q <= top_idx_q - TW'(1);
            state_q   <= ST_PWAIT;
          end else if (!busy_q || preempt || !top_gt) begin
            // the head leaves its FIFO: run it, or preempt, or park it
            if (!busy_q || preempt) run_q <= head_q;
            busy_q <= 1'b1;
            if (busy_q) begin
              if (stk_full) drop_q <= 1'b1;
              else top_idx_q <= top_idx_q + TW'(1);
            end
            rptr_q[lvl_q] <= rnext;
            fill_q[lvl_q] <= fill_q[lvl_q] - CW'(1);
            if (!lvl_last) begin
              state_q <= ST_SCAN;
            end else if (lvl_q == '0) begin
              state_q <= ST_FWAIT;
            end else begin
              lvl_q   <= lvl_q - LW'(1);
              state_q <= ST_SCAN;
            end
          end else begin
            // the head waits: the level stays busy, stop the scan here
            state_q <= ST_FWAIT;
          end
        end
        ST_PWAIT: begin
          state_q <= ST_PARK;
        end
        ST_PARK: begin
          // park the head unless the new stack top outranks it
          if (park_now) begin
            if (stk_full) drop_q <= 1'b1;
            else top_idx_q <= top_idx_q + TW'(1);
            rptr_q[lvl_q] <= rnext;
            fill_q[lvl_q] <= fill_q[lvl_q] - CW'(1);
            if (!lvl_last) begin
              state_q <= ST_SCAN;
            end else if (lvl_q == '0) begin
              state_q <= ST_FWAIT;
            end else begin
              lvl_q   <= lvl_q - LW'(1);
              state_q <= ST_SCAN;
            end
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_FWAIT: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // spend one tick on the running task; drop it at zero remaining
          if (fin_pop) top_idx_q <= top_idx_q - TW'(1);
          busy_q <= fin_live;
          run_q  <= fin_live ? '{lvl: fin_cur.lvl, dur: fin_cur.dur, rest: fin_rest,
                                 tag: fin_cur.tag} : '0;
          res_q <= '{running_valid: fin_act,
                     running_tag:   fin_act ? fin_cur.tag : '0,
                     running_left:  fin_act ? fin_rest : '0,
                     task_finished: fin_act && (fin_rest == 16'd0),
                     all_idle: fin_idle, dropped: drop_q, tick_number: tick_q};
          tick_q    <= tick_q + 16'd1;
          res_vld_q <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ready |-> !res_vld_q)
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(top_idx_q) <= STACK_DEPTH))
    else $error("stack overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> $stable(res_o.data))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
endmodule
